>>> src/tatp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trapezoid profile package
// Shared types, register indexes, and saturation and magnitude helpers.
// ----------------------------------------------------------------------------
package tatp_pkg;

  localparam int unsigned AXES = 3;
  localparam int unsigned AX_W = (AXES > 1) ? $clog2(AXES) : 1;

  // Configuration register indexes.
  localparam logic [1:0] REG_ACCEL_LIMIT = 2'd0;
  localparam logic [1:0] REG_SPEED_LIMIT = 2'd1;
  localparam logic [1:0] REG_TICK_RATE   = 2'd2;

  typedef struct packed {
    logic        command;
    logic [31:0] target_x;
    logic [31:0] target_y;
    logic [31:0] target_z;
  } in_beat_t;

  typedef struct packed {
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [31:0] vel_x;
    logic [31:0] vel_y;
    logic [31:0] vel_z;
    logic [31:0] acc_x;
    logic [31:0] acc_y;
    logic [31:0] acc_z;
    logic [2:0]  arrived_mask;
  } out_beat_t;

  // Clamp a 34-bit signed sum into the 32-bit signed range.
  function automatic logic [31:0] sat32(input logic [33:0] x);
    logic [31:0] r;
    if (!x[33] && (x[32:31] != 2'b00)) begin
      r = 32'h7FFF_FFFF;
    end else if (x[33] && (x[32:31] != 2'b11)) begin
      r = 32'h8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  // Magnitude of a 32-bit signed value as unsigned.
  function automatic logic [31:0] abs32(input logic [31:0] x);
    return x[31] ? (~x + 32'd1) : x;
  endfunction

endpackage

>>> src/three_axis_trapezoid_profile_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Three-axis trapezoid profile unit
// Steps a reference point on each axis toward its target per control tick,
// or loads the targets as positions on a load command.
// Sequencing: a load command walks the axes in the setup state; an advance takes
// each axis through up to four divisions on the shared radix-2 restoring
// divider. Input: a new beat is accepted only while idle, after the last one
// has ended; the next beat is taken while a result waits.
// Reset: positions, velocities, accelerations and done bits clear to zero,
// registers take their defaults.
module three_axis_trapezoid_profile_unit
  import tatp_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [30:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_beat_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_beat_t   out_data_o
);

  localparam longint unsigned ONE_Q   = 64'd1 << FRAC_BITS;
  localparam longint unsigned EPS_RAW = (ONE_Q + 500) / 1000;
  localparam logic [32:0] EPS  = (EPS_RAW > 0) ? 33'(EPS_RAW) : 33'd1;
  localparam logic [31:0] VEPS = 32'((ONE_Q + 5) / 10);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_SETUP = 11'b00000000010,
    S_SQ    = 11'b00000000100,
    S_DIV   = 11'b00000001000,
    S_STOP  = 11'b00000010000,
    S_BRAKE = 11'b00000100000,
    S_ACC   = 11'b00001000000,
    S_VEL   = 11'b00010000000,
    S_VDIV  = 11'b00100000000,
    S_POS   = 11'b01000000000,
    S_DONE  = 11'b10000000000
  } state_e;

  state_e      state_q, ret_q;
  logic [30:0] accel_q, speed_q;
  logic [9:0]  rate_q;
  logic        cmd_q;
  logic [31:0] tgt_q [AXES];
  logic [31:0] pos_q [AXES];
  logic [31:0] vel_q [AXES];
  logic [31:0] acc_q [AXES];
  logic [AXES-1:0] done_q;
  logic [AX_W-1:0] ax_q;
  logic [32:0] d_q, absd_q;
  logic [31:0] absv_q;
  logic [63:0] v2_q;
  logic [33:0] rem_q, dsr_q;
  logic [63:0] quo_q;
  logic [5:0]  cnt_q;
  logic        out_valid_q;
  out_beat_t   out_q;

  // Effective limits: zero is used as one.
  logic [30:0] a_eff;
  logic [9:0]  rate_eff;
  assign a_eff    = (accel_q == '0) ? 31'd1 : accel_q;
  assign rate_eff = (rate_q == '0) ? 10'd1 : rate_q;

  // Current axis operands.
  logic [31:0] cur_p, cur_t, cur_v, cur_a;
  logic [32:0] cur_d, cur_absd;
  logic [31:0] cur_absv;
  logic        last_ax;
  assign cur_p    = pos_q[ax_q];
  assign cur_t    = tgt_q[ax_q];
  assign cur_v    = vel_q[ax_q];
  assign cur_a    = acc_q[ax_q];
  assign cur_d    = {cur_t[31], cur_t} - {cur_p[31], cur_p};
  assign cur_absd = cur_d[32] ? (~cur_d + 33'd1) : cur_d;
  assign cur_absv = abs32(cur_v);
  assign last_ax  = (ax_q == AX_W'(AXES - 1));

  // One restoring divider step.
  logic [34:0] rem_sh;
  logic        div_ge;
  logic [34:0] rem_sub;
  assign rem_sh  = {rem_q, quo_q[63]};
  assign div_ge  = (rem_sh >= {1'b0, dsr_q});
  assign rem_sub = rem_sh - {1'b0, dsr_q};

  // Braking magnitude, clamped to 2^31, signed against the distance.
  logic [31:0] brake_m, brake_acc;
  assign brake_m   = (quo_q > 64'h8000_0000) ? 32'h8000_0000 : quo_q[31:0];
  assign brake_acc = !d_q[32] ? (~brake_m + 32'd1)
                              : (brake_m[31] ? 32'h7FFF_FFFF : brake_m);

  // Signed quotient for the integration steps.
  logic [33:0] q_pos, q_neg;
  assign q_pos = {1'b0, quo_q[32:0]};
  assign q_neg = ~q_pos + 34'd1;

  logic [33:0] vel_sum, pos_sum;
  assign vel_sum = {cur_v[31], cur_v[31], cur_v} + (cur_a[31] ? q_neg : q_pos);
  assign pos_sum = {cur_p[31], cur_p[31], cur_p} + (cur_v[31] ? q_neg : q_pos);

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accel_q <= 31'd65536;
      speed_q <= 31'd65536;
      rate_q  <= 10'd30;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ACCEL_LIMIT: accel_q <= cfg_wdata_i;
        REG_SPEED_LIMIT: speed_q <= cfg_wdata_i;
        REG_TICK_RATE:   rate_q  <= cfg_wdata_i[9:0];
        default: ;
      endcase
    end
  end

  // Sequencer, shared divider and axis state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ret_q       <= S_IDLE;
      ax_q        <= '0;
      done_q      <= '0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      for (int i = 0; i < AXES; i++) begin
        pos_q[i] <= '0;
        vel_q[i] <= '0;
        acc_q[i] <= '0;
      end
    end else begin
      // The result beat leaves; the done state refills the slot itself.
      if (out_valid_q && out_ready_i && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            cmd_q    <= in_data_i.command;
            tgt_q[0] <= in_data_i.target_x;
            tgt_q[1] <= in_data_i.target_y;
            tgt_q[2] <= in_data_i.target_z;
            ax_q     <= '0;
            state_q  <= S_SETUP;
          end
        end
        S_SETUP: begin
          if (cmd_q) begin
            pos_q[ax_q] <= cur_t;
            state_q     <= last_ax ? S_DONE : S_SETUP;
            ax_q        <= ax_q + AX_W'(1);
          end else if (cur_absd < EPS) begin
            // Near the target: snap only when slow enough.
            if (cur_absv < VEPS) begin
              pos_q[ax_q]  <= cur_t;
              vel_q[ax_q]  <= '0;
              acc_q[ax_q]  <= '0;
              done_q[ax_q] <= 1'b1;
            end
            state_q <= last_ax ? S_DONE : S_SETUP;
            ax_q    <= ax_q + AX_W'(1);
          end else begin
            done_q[ax_q] <= 1'b0;
            d_q          <= cur_d;
            absd_q       <= cur_absd;
            absv_q       <= cur_absv;
            state_q      <= S_SQ;
          end
        end
        S_SQ: begin
          // Stopping distance v^2 / 2a.
          v2_q    <= absv_q * absv_q;
          quo_q   <= absv_q * absv_q;
          rem_q   <= '0;
          dsr_q   <= {2'b00, a_eff, 1'b0};
          cnt_q   <= '1;
          ret_q   <= S_STOP;
          state_q <= S_DIV;
        end
        S_DIV: begin
          rem_q <= div_ge ? rem_sub[33:0] : rem_sh[33:0];
          quo_q <= {quo_q[62:0], div_ge};
          cnt_q <= cnt_q - 6'd1;
          if (cnt_q == '0) begin
            state_q <= ret_q;
          end
        end
        S_STOP: begin
          if (quo_q >= {31'b0, absd_q}) begin
            quo_q   <= v2_q;
            rem_q   <= '0;
            dsr_q   <= {absd_q, 1'b0};
            cnt_q   <= '1;
            ret_q   <= S_BRAKE;
            state_q <= S_DIV;
          end else if ({1'b0, absv_q} > {2'b00, speed_q}) begin
            acc_q[ax_q] <= '0;
            state_q     <= S_ACC;
          end else begin
            acc_q[ax_q] <= !d_q[32] ? {1'b0, a_eff} : (~{1'b0, a_eff} + 32'd1);
            state_q     <= S_ACC;
          end
        end
        S_BRAKE: begin
          acc_q[ax_q] <= brake_acc;
          state_q     <= S_ACC;
        end
        S_ACC: begin
          quo_q   <= {32'b0, abs32(cur_a)};
          rem_q   <= '0;
          dsr_q   <= {24'b0, rate_eff};
          cnt_q   <= '1;
          ret_q   <= S_VEL;
          state_q <= S_DIV;
        end
        S_VEL: begin
          vel_q[ax_q] <= sat32(vel_sum);
          state_q     <= S_VDIV;
        end
        S_VDIV: begin
          quo_q   <= {32'b0, abs32(cur_v)};
          rem_q   <= '0;
          dsr_q   <= {24'b0, rate_eff};
          cnt_q   <= '1;
          ret_q   <= S_POS;
          state_q <= S_DIV;
        end
        S_POS: begin
          pos_q[ax_q] <= sat32(pos_sum);
          state_q     <= last_ax ? S_DONE : S_SETUP;
          ax_q        <= ax_q + AX_W'(1);
        end
        S_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_q.pos_x        <= pos_q[0];
            out_q.pos_y        <= pos_q[1];
            out_q.pos_z        <= pos_q[2];
            out_q.vel_x        <= vel_q[0];
            out_q.vel_y        <= vel_q[1];
            out_q.vel_z        <= vel_q[2];
            out_q.acc_x        <= acc_q[0];
            out_q.acc_y        <= acc_q[1];
            out_q.acc_z        <= acc_q[2];
            out_q.arrived_mask <= done_q;
            out_valid_q        <= 1'b1;
            state_q            <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(state_q))
    else $error("sequencer state is not one-hot");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready after accepting a beat");
  a_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (rem_q < dsr_q))
    else $error("divider remainder not below divisor");
  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |=> $stable(done_q))
    else $error("done bits changed while idle");
`endif

endmodule
